FILE: rtl/core/assert_macros.svh
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/lwc_pkg.sv
`default_nettype none

package lwc_pkg;

   localparam int unsigned THR_BITS  = 32;
   localparam int unsigned MS_BITS   = 8;
   localparam int unsigned LINE_BITS = 15;
   localparam int unsigned TICK_BITS = 32;
   localparam int unsigned OUT_BITS  = 32;
   localparam int unsigned PCT_BITS  = 16;
   localparam int unsigned CNT_BITS  = 5;
   localparam int unsigned IDX_BITS  = 8;

   localparam logic [THR_BITS-1:0]  THR_RESET = 32'd20000;
   localparam logic [MS_BITS-1:0]   MS_RESET  = 8'd25;
   localparam logic [LINE_BITS-1:0] LINE_MAX  = 15'h7FFF;
   localparam logic [PCT_BITS-1:0]  PCT_MAX   = 16'hFFFF;
   localparam logic [CNT_BITS-1:0]  DIV_FIRST = 5'd16;

   localparam logic [IDX_BITS-1:0] REG_WHITE_THRESHOLD = 8'd0;
   localparam logic [IDX_BITS-1:0] REG_MS_PER_TICK     = 8'd1;

   typedef enum logic [2:0] {
      EVT_NONE    = 3'd0,
      EVT_REF     = 3'd1,
      EVT_THIN    = 3'd2,
      EVT_THICK   = 3'd3,
      EVT_INVALID = 3'd4
   } lwc_event_type;

   typedef struct packed {
      logic load_in;
      logic classify;
      logic decide;
      logic div_step;
      logic load_out;
   } lwc_cmd_type;

   typedef struct packed {
      logic need_decide;
      logic need_div;
      logic div_done;
   } lwc_sts_type;

endpackage

`default_nettype wire

FILE: rtl/core/lwc_ctrl.sv
`default_nettype none

module lwc_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   input  lwc_pkg::lwc_sts_type sts,
   output lwc_pkg::lwc_cmd_type cmd
);
   import lwc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_CLASS  = 5'b00010,
      S_DECIDE = 5'b00100,
      S_DIV    = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign out_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_CLASS;
         S_CLASS:  state_in = sts.need_decide ? S_DECIDE : S_DONE;
         S_DECIDE: state_in = sts.need_div ? S_DIV : S_DONE;
         S_DIV:    if (sts.div_done) state_in = S_DONE;
         S_DONE:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.load_in  = (state_ff == S_IDLE) && req_tvalid;
      cmd.classify = (state_ff == S_CLASS);
      cmd.decide   = (state_ff == S_DECIDE);
      cmd.div_step = (state_ff == S_DIV);
      cmd.load_out = (state_ff == S_DONE) && out_free;
   end

   // hold a result until taken, drop it on handoff
   always_comb begin
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/lwc_dpath.sv
`default_nettype none

module lwc_dpath #(
   parameter int unsigned TIME_BITS = 32
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     csr_we,
   input  wire  [lwc_pkg::IDX_BITS-1:0]            csr_index,
   input  wire  [lwc_pkg::THR_BITS-1:0]            csr_wdata,
   input  wire  [lwc_pkg::THR_BITS-1:0]            decay_count,
   input  wire  [lwc_pkg::OUT_BITS-1:0]            timestamp,
   input  lwc_pkg::lwc_cmd_type                    cmd,
   output lwc_pkg::lwc_sts_type                    sts,
   output logic                                    is_white,
   output lwc_pkg::lwc_event_type                  event_res,
   output logic [lwc_pkg::OUT_BITS-1:0]            line_width,
   output logic [lwc_pkg::LINE_BITS-1:0]           lines_seen,
   output logic [lwc_pkg::OUT_BITS-1:0]            run_time_ms,
   output logic [lwc_pkg::PCT_BITS-1:0]            width_percent
);
   import lwc_pkg::*;

   localparam int unsigned TW = TIME_BITS;
   localparam int unsigned CW = TIME_BITS + 4;
   localparam int unsigned NW = TIME_BITS + PCT_BITS;

   // configuration
   logic [THR_BITS-1:0]  thr_ff;
   logic [MS_BITS-1:0]   ms_ff;

   // latched item
   logic [THR_BITS-1:0]  decay_ff;
   logic [TW-1:0]        now_ff;

   // line tracking state
   logic                 on_white_ff, on_white_in;
   logic [TW-1:0]        black_start_ff, black_start_in;
   logic [TW-1:0]        ref_ff, ref_in;
   logic [LINE_BITS-1:0] line_cnt_ff, line_cnt_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in;

   // per-item working registers
   logic                 white_ff;
   logic [TW-1:0]        width_ff, width_in;
   logic [OUT_BITS-1:0]  run_ff;
   lwc_event_type        event_ff, event_in;
   logic [NW-1:0]        rem_ff, div_ff;
   logic [PCT_BITS-1:0]  quo_ff;
   logic [CNT_BITS-1:0]  cnt_ff;

   logic                 white_now, rising_white, first_line;
   logic [CW-1:0]        w_ext, r_ext, w10, r2, w2, r3;
   logic                 is_thin, is_thick;
   logic [NW-1:0]        w_n, n100;
   logic                 div_ge, div_first;

   // classify
   assign white_now    = decay_ff < thr_ff;
   assign rising_white = white_now && !on_white_ff;
   assign first_line   = (line_cnt_ff == '0);

   always_comb begin
      on_white_in    = on_white_ff;
      black_start_in = black_start_ff;
      ref_in         = ref_ff;
      line_cnt_in    = line_cnt_ff;
      tick_in        = tick_ff + TICK_BITS'(1);
      width_in       = '0;
      event_in       = EVT_NONE;
      if (rising_white) begin
         width_in    = now_ff - black_start_ff;
         on_white_in = 1'b1;
         if (line_cnt_ff != LINE_MAX) line_cnt_in = line_cnt_ff + LINE_BITS'(1);
         if (first_line) begin
            ref_in   = now_ff - black_start_ff;
            tick_in  = TICK_BITS'(1);
            event_in = EVT_REF;
         end
      end else if (!white_now && on_white_ff) begin
         black_start_in = now_ff;
         on_white_in    = 1'b0;
      end
   end

   // width against reference: w*10 > r*2 and w*2 < r*3 is thin, w*2 > r*3 thick
   assign w_ext    = CW'(width_ff);
   assign r_ext    = CW'(ref_ff);
   assign w10      = (w_ext << 3) + (w_ext << 1);
   assign r2       = r_ext << 1;
   assign w2       = w_ext << 1;
   assign r3       = (r_ext << 1) + r_ext;
   assign is_thin  = (w10 > r2) && (w2 < r3);
   assign is_thick = !is_thin && (w2 > r3);
   assign w_n      = NW'(width_ff);
   assign n100     = (w_n << 6) + (w_n << 5) + (w_n << 2);

   // restoring division, first step only checks for saturation
   assign div_ge    = rem_ff >= div_ff;
   assign div_first = (cnt_ff == DIV_FIRST);

   always_comb begin
      sts.need_decide = rising_white && !first_line;
      sts.need_div    = !is_thin && !is_thick;
      sts.div_done    = (div_first && div_ge) || (cnt_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff         <= THR_RESET;
         ms_ff          <= MS_RESET;
         on_white_ff    <= 1'b1;
         black_start_ff <= '0;
         ref_ff         <= '0;
         line_cnt_ff    <= '0;
         tick_ff        <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_WHITE_THRESHOLD: thr_ff <= csr_wdata;
               REG_MS_PER_TICK:     ms_ff  <= csr_wdata[MS_BITS-1:0];
               default: ;
            endcase
         end
         if (cmd.classify) begin
            on_white_ff    <= on_white_in;
            black_start_ff <= black_start_in;
            ref_ff         <= ref_in;
            line_cnt_ff    <= line_cnt_in;
            tick_ff        <= tick_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         decay_ff <= decay_count;
         now_ff   <= TW'(timestamp);
      end
      if (cmd.classify) begin
         white_ff <= white_now;
         width_ff <= width_in;
         event_ff <= event_in;
         run_ff   <= OUT_BITS'(tick_ff * ms_ff);
      end
      if (cmd.decide) begin
         event_ff <= is_thin ? EVT_THIN : (is_thick ? EVT_THICK : EVT_INVALID);
         rem_ff   <= n100;
         div_ff   <= NW'(ref_ff) << PCT_BITS;
         quo_ff   <= '0;
         cnt_ff   <= DIV_FIRST;
      end
      if (cmd.div_step) begin
         if (div_first) begin
            if (div_ge) quo_ff <= PCT_MAX;
         end else if (div_ge) begin
            rem_ff <= rem_ff - div_ff;
            quo_ff <= quo_ff | (PCT_BITS'(1) << cnt_ff[CNT_BITS-2:0]);
         end
         div_ff <= div_ff >> 1;
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
      if (cmd.load_out) begin
         is_white      <= white_ff;
         event_res     <= event_ff;
         line_width    <= OUT_BITS'(width_ff);
         lines_seen    <= line_cnt_ff;
         run_time_ms   <= (event_ff == EVT_THICK) ? run_ff : '0;
         width_percent <= (event_ff == EVT_INVALID) ? quo_ff : '0;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/line_width_classifier.sv
// Every accepted item is classified; a tick without a line edge or the reference line then
// goes straight to the result, a thin or thick line passes the decide state, and an invalid width
// also runs the percent divider (one quotient bit per cycle, 16 bits plus a saturation check).
// Only one item is in flight: req_tready returns once the result is queued.
// Reset (synchronous, active high): threshold 20000, 25 ms per tick, on white, counters cleared.
`default_nettype none

module line_width_classifier #(
   parameter int unsigned TIME_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // decay_count[31:0], timestamp[63:32]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [95:0] rsp_tdata,   // is_white[0], line_width[32:1], lines_seen[47:33],
                                    // run_time_ms[79:48], width_percent[95:80]
   output logic [2:0]  rsp_tuser,   // event_res[2:0]
   input  wire         csr_we,
   input  wire  [7:0]  csr_index,
   input  wire  [31:0] csr_wdata
);
   import lwc_pkg::*;

   lwc_cmd_type               cmd;
   lwc_sts_type               sts;
   logic                      is_white;
   lwc_event_type             event_res;
   logic [OUT_BITS-1:0]       line_width;
   logic [LINE_BITS-1:0]      lines_seen;
   logic [OUT_BITS-1:0]       run_time_ms;
   logic [PCT_BITS-1:0]       width_percent;

   lwc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lwc_dpath #(
      .TIME_BITS (TIME_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .decay_count   (req_tdata[31:0]),
      .timestamp     (req_tdata[63:32]),
      .cmd           (cmd),
      .sts           (sts),
      .is_white      (is_white),
      .event_res     (event_res),
      .line_width    (line_width),
      .lines_seen    (lines_seen),
      .run_time_ms   (run_time_ms),
      .width_percent (width_percent)
   );

   assign rsp_tdata = {width_percent, run_time_ms, lines_seen, line_width, is_white};
   assign rsp_tuser = event_res;

endmodule

`default_nettype wire

FILE: rtl/core/lwc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module lwc_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [95:0] rsp_tdata,
   input wire [2:0]  rsp_tuser
);
   import lwc_pkg::*;

   // one item at a time: busy right after an accept
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, req_tready && !rsp_tvalid)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // a line edge is only ever reported on a white tick
   `ASSERT_SAME(a_event_white, clock, reset, rsp_tvalid && rsp_tuser != EVT_NONE, rsp_tdata[0])
   `ASSERT_SAME(a_none_zero, clock, reset, rsp_tvalid && rsp_tuser == EVT_NONE, rsp_tdata[32:1] == 32'd0 && rsp_tdata[95:48] == 48'd0)

endmodule

bind line_width_classifier lwc_checker u_lwc_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lwc_pkg::*;

   localparam logic [IDX_BITS-1:0] REG_UNUSED = 8'hFF;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 40;

   typedef struct packed {
      logic          is_white;
      lwc_event_type kind;
      logic [31:0]   width;
      logic [14:0]   lines;
      logic [31:0]   run_ms;
      logic [15:0]   pct;
   } tick_outcome_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [7:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   line_width_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // predictor copy of the block's registers and state
   logic [31:0] thr_now = THR_RESET;
   logic [7:0]  ms_now = MS_RESET;
   logic        on_white = 1'b1;
   logic [31:0] black_start = '0;
   logic [31:0] ref_width = '0;
   logic [14:0] line_count = '0;
   logic [31:0] tick_count = '0;

   logic [63:0]      tick_q[$];      // decay_count[31:0], timestamp[63:32]
   tick_outcome_type outcome_q[$];
   tick_outcome_type want;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   // generator state
   logic [31:0] line_ts;
   logic [31:0] gen_ref_width;

   function automatic tick_outcome_type predict_tick(input logic [31:0] decay,
                                                     input logic [31:0] ts);
      tick_outcome_type o;
      logic [63:0]      w;
      logic [63:0]      r;
      logic [63:0]      q;
      o = '0;
      o.is_white = decay < thr_now;
      if (o.is_white) begin
         if (!on_white) begin
            w = {32'b0, ts - black_start};
            r = {32'b0, ref_width};
            o.width = w[31:0];
            on_white = 1'b1;
            if (line_count == '0) begin
               ref_width = w[31:0];
               tick_count = '0;
               o.kind = EVT_REF;
            end else if (w * 10 > r * 2 && w * 2 < r * 3) begin
               o.kind = EVT_THIN;
            end else if (w * 2 > r * 3) begin
               o.kind = EVT_THICK;
               o.run_ms = tick_count * ms_now;
            end else begin
               o.kind = EVT_INVALID;
               if (r == 0 || w * 100 >= (r << 16)) begin
                  o.pct = PCT_MAX;
               end else begin
                  q = (w * 100) / r;
                  o.pct = q[15:0];
               end
            end
            if (line_count != LINE_MAX) line_count = line_count + 1'b1;
         end
      end else if (on_white) begin
         black_start = ts;
         on_white = 1'b0;
      end
      tick_count = tick_count + 1;
      o.lines = line_count;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      if (mismatches < MAX_REPORTS)
         $display("%0t mismatch %s: got 0x%08h want 0x%08h", $realtime, what, got, exp_val);
      mismatches++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            outcome_q.push_back(predict_tick(req_tdata[31:0], req_tdata[63:32]));
         if (!req_tvalid || req_tready) begin
            if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= tick_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               report_mismatch("unexpected item, event", {29'b0, rsp_tuser}, '0);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_tdata[0] !== want.is_white)
                  report_mismatch("is_white", {31'b0, rsp_tdata[0]}, {31'b0, want.is_white});
               if (rsp_tuser !== want.kind)
                  report_mismatch("event_res", {29'b0, rsp_tuser}, {29'b0, want.kind});
               if (rsp_tdata[32:1] !== want.width)
                  report_mismatch("line_width", rsp_tdata[32:1], want.width);
               if (rsp_tdata[47:33] !== want.lines)
                  report_mismatch("lines_seen", {17'b0, rsp_tdata[47:33]}, {17'b0, want.lines});
               if (rsp_tdata[79:48] !== want.run_ms)
                  report_mismatch("run_time_ms", rsp_tdata[79:48], want.run_ms);
               if (rsp_tdata[95:80] !== want.pct)
                  report_mismatch("width_percent", {16'b0, rsp_tdata[95:80]}, {16'b0, want.pct});
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog: restart on any accepted item
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** line_width_classifier: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (tick_q.size() != 0 || req_tvalid || outcome_q.size() != 0);
   endtask

   task automatic write_csr(input logic [7:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == REG_WHITE_THRESHOLD) thr_now = val;
      else if (idx == REG_MS_PER_TICK) ms_now = val[7:0];
   endtask

   function automatic logic [31:0] white_decay();
      if ($urandom_range(0, 7) == 0) return thr_now - 1;
      return $urandom_range(0, thr_now - 1);
   endfunction

   function automatic logic [31:0] black_decay();
      case ($urandom_range(0, 7))
         0: return thr_now;
         1: return 32'hFFFF_FFFF;
         default: return $urandom_range(thr_now, 32'hFFFF_FFFF);
      endcase
   endfunction

   function automatic logic [31:0] pick_width(input logic [31:0] r);
      logic [63:0] r64;
      logic [63:0] w;
      r64 = {32'b0, r};
      case ($urandom_range(0, 9))
         0, 1, 2: w = r64 * $urandom_range(3, 14) / 10;
         3, 4:    w = r64 * $urandom_range(16, 60) / 10;
         5:       w = r64 / 5 + $urandom_range(0, 1);
         6:       w = r64 * 3 / 2 + $urandom_range(0, 2) - 1;
         7:       w = $urandom_range(0, 3);
         8:       w = {32'b0, $urandom()};
         default: w = r64 + $urandom_range(0, 8) - 4;
      endcase
      return w[31:0];
   endfunction

   // whites (optional), a black edge with optional extra black ticks, then the closing white
   task automatic push_line(input logic [31:0] width, input int n_black, input int n_white);
      logic [31:0] start;
      repeat (n_white) tick_q.push_back({$urandom(), white_decay()});
      start = line_ts;
      tick_q.push_back({start, black_decay()});
      repeat (n_black - 1)
         tick_q.push_back({start + $urandom_range(0, 500), black_decay()});
      tick_q.push_back({start + width, white_decay()});
      if ($urandom_range(0, 15) == 0) line_ts = $urandom();
      else line_ts = start + width + $urandom_range(1, 1000);
   endtask

   task automatic run_phase(input logic [31:0] thr, input logic [7:0] ms, input int send_pct,
                            input int recv_pct, input int n_ticks);
      wait_drained();
      write_csr(REG_WHITE_THRESHOLD, thr);
      write_csr(REG_UNUSED, $urandom());
      write_csr(REG_MS_PER_TICK, {24'b0, ms});
      @(posedge clock);
      csr_we <= 1'b0;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      while (tick_q.size() < n_ticks) begin
         if (thr_now == '0 || $urandom_range(0, 9) == 0)
            tick_q.push_back({$urandom(), $urandom()});
         else
            push_line(pick_width(gen_ref_width), $urandom_range(1, 3),
                      $urandom_range(0, 2));
      end
   endtask

   initial begin
      logic [31:0] w_list[7];
      // reference width: zero in about one run of four
      if ($urandom_range(0, 3) == 0) gen_ref_width = '0;
      else if ($urandom_range(0, 1) == 0) gen_ref_width = 32'd1000;
      else gen_ref_width = $urandom_range(10, 32'h7FFF_FFFF);

      // directed: both sides of the threshold, timer wrap on the reference line
      tick_q.push_back({32'h0000_0000, 32'h0000_0000});
      tick_q.push_back({$urandom(), 32'd19999});
      tick_q.push_back({32'hFFFF_FFF0, 32'd20000});
      tick_q.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF});
      tick_q.push_back({32'hFFFF_FFF0 + gen_ref_width, 32'd0});
      w_list[0] = gen_ref_width;
      w_list[1] = gen_ref_width * 3 / 2;
      w_list[2] = gen_ref_width * 3 / 2 + 1;
      w_list[3] = gen_ref_width / 5;
      w_list[4] = gen_ref_width / 5 + 1;
      w_list[5] = '0;
      w_list[6] = 32'hFFFF_FFFF;
      line_ts = 32'h0000_1000;
      foreach (w_list[i]) push_line(w_list[i], 1, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_phase($urandom_range(100, 32'h7FFF_FFFF), 8'($urandom()), 0, 0, 160);
      run_phase(32'hFFFF_FFFF, 8'hFF, 53, 0, 160);
      run_phase(32'h0000_0000, 8'h00, 0, 53, 40);
      run_phase(32'h0000_0001, 8'h01, 21, 21, 160);
      run_phase($urandom(), 8'($urandom()), 0, 0, 160);
      run_phase(THR_RESET, MS_RESET, 53, 0, 160);
      run_phase(32'h8000_0000, 8'h80, 0, 53, 160);
      run_phase($urandom(), 8'($urandom()), 21, 21, 160);
      run_phase($urandom_range(1000, 32'hFFFF_FFFE), 8'($urandom()), 21, 21, 120);

      wait_drained();
      repeat (24) @(posedge clock);
      if (mismatches == 0) begin
         $display("** line_width_classifier: PASSED **");
      end else begin
         $display("** line_width_classifier: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
